### src/handheld_memory_bus_decoder_unit_assert.svh
// Assertion macros for the memory bus decoder.
// No dependencies; included by the top level.
`ifndef HANDHELD_MEMORY_BUS_DECODER_UNIT_ASSERT_SVH
`define HANDHELD_MEMORY_BUS_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HMBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hmbd assertion failed");

// Next-cycle implication, disabled during reset.
`define HMBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hmbd assertion failed");

`endif

### src/hmbd_pkg.sv
// Shared types, constants and address decode for the memory bus decoder.
// No dependencies.
`default_nettype none

package hmbd_pkg;

    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 16;
    localparam int OP_W    = 3;
    localparam int MEM_AW  = 15;   // byte store covers 0x8000-0xFFFF
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [ADDR_W-1:0] SP_RESET = 16'hFFFE;
    localparam logic [7:0]        GAP_PAGE = 8'hFE;
    localparam logic [7:0]        GAP_LOW  = 8'hA0;

    // register index, taken from paddr[PADDR_W-1]
    localparam logic CFG_IDX_STACK_START = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_RD_BYTE   = 3'd0,
        OP_WR_BYTE   = 3'd1,
        OP_RD_WORD   = 3'd2,
        OP_WR_WORD   = 3'd3,
        OP_PUSH_BYTE = 3'd4,
        OP_POP_BYTE  = 3'd5,
        OP_PUSH_WORD = 3'd6,
        OP_POP_WORD  = 3'd7
    } t_op;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

    typedef struct packed {
        logic rom;
        logic gap;
        logic mapped;
    } t_area;

    function automatic t_area decode_area(input logic [ADDR_W-1:0] a);
        t_area r;
        r.rom    = ~a[ADDR_W-1];
        r.gap    = (a[15:8] == GAP_PAGE) && (a[7:0] >= GAP_LOW);
        r.mapped = a[ADDR_W-1] && !r.gap;
        return r;
    endfunction

endpackage

`default_nettype wire

### src/hmbd_if.sv
// Handshake channels of the memory bus decoder: operation in, result out.
// Depends on hmbd_pkg.
`default_nettype none

interface hmbd_in_if;
    logic                          valid;
    logic                          ready;
    logic [hmbd_pkg::OP_W-1:0]     operation;
    logic [hmbd_pkg::ADDR_W-1:0]   address;
    logic [hmbd_pkg::DATA_W-1:0]   write_data;

    modport source (output valid, output operation, output address, output write_data,
                    input ready);
    modport sink   (input valid, input operation, input address, input write_data,
                    output ready);
endinterface

interface hmbd_out_if;
    logic                          valid;
    logic                          ready;
    logic [hmbd_pkg::DATA_W-1:0]   read_data;
    logic                          rom_area;
    logic                          invalid_area;
    logic [hmbd_pkg::ADDR_W-1:0]   stack_pointer;

    modport source (output valid, output read_data, output rom_area, output invalid_area,
                    output stack_pointer, input ready);
    modport sink   (input valid, input read_data, input rom_area, input invalid_area,
                    input stack_pointer, output ready);
endinterface

`default_nettype wire

### src/hmbd_store.sv
// Byte store for 0x8000-0xFFFF with a clearing sweep after reset.
// Depends on hmbd_pkg.
`default_nettype none

module hmbd_store (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hmbd_pkg::t_mem_req i_req,
    output logic [7:0]              o_rdata,
    output logic                    o_clear_busy
);

    localparam int DEPTH = 2 ** hmbd_pkg::MEM_AW;

    logic [7:0]                  r_mem [DEPTH];
    logic [7:0]                  r_rdata;
    logic [hmbd_pkg::MEM_AW-1:0] r_clr_cnt;
    logic                        r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt  <= '0;
            r_clr_busy <= 1'b1;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // sweep has the write port until done
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_cnt] <= 8'h00;
        end else if (i_req.en && i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en && !i_req.we) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata      = r_rdata;
    assign o_clear_busy = r_clr_busy;

endmodule

`default_nettype wire

### src/handheld_memory_bus_decoder_unit.sv
// Channel        | Dir | Fields
// i_in           | in  | operation[2:0], address[15:0], write_data[15:0]
// o_out          | out | read_data[15:0], rom_area, invalid_area, stack_pointer[15:0]
// APB (psel...)  | in  | stack_start at byte address 0
//
// A byte operation passes S_IDLE and S_FIN, a word operation S_IDLE, S_HI and S_FIN:
// one access per byte on the single-port byte store, then S_FIN collects the registered read data.
// After reset the store is cleared one byte a cycle, all 32768 bytes, with i_in held off.
// The result register lets the next transaction start while a result waits;
// a finished item stalls only when the previous result is still untaken.
// Depends on hmbd_pkg, hmbd_if, hmbd_store and the assertion header.
`default_nettype none
`include "handheld_memory_bus_decoder_unit_assert.svh"

module handheld_memory_bus_decoder_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    hmbd_in_if.sink                             i_in,
    hmbd_out_if.source                          o_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [hmbd_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [hmbd_pkg::PDATA_W-1:0]   pwdata,
    output logic [hmbd_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_HI   = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                      r_state, n_state;
    logic [hmbd_pkg::ADDR_W-1:0] r_sp, r_stack_start;
    logic [hmbd_pkg::ADDR_W-1:0] r_addr;
    logic [hmbd_pkg::DATA_W-1:0] r_data;
    logic                        r_word, r_wr, r_cur_map, r_rom, r_gap;
    logic [7:0]                  r_lo;

    logic                        r_out_valid;
    logic [hmbd_pkg::DATA_W-1:0] r_out_data;
    logic                        r_out_rom, r_out_gap;
    logic [hmbd_pkg::ADDR_W-1:0] r_out_sp;

    hmbd_pkg::t_op               op;
    logic [hmbd_pkg::ADDR_W-1:0] base_addr, n_sp, hi_addr;
    logic                        op_word, op_wr, accept, cfg_wr, out_free, clear_busy;
    hmbd_pkg::t_area             area_lo, area_hi;
    hmbd_pkg::t_mem_req          mem_req;
    logic [7:0]                  mem_rdata, last_byte;

    assign op       = hmbd_pkg::t_op'(i_in.operation);
    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign cfg_wr   = psel && penable && pwrite && pready
                      && (paddr[hmbd_pkg::PADDR_W-1] == hmbd_pkg::CFG_IDX_STACK_START);

    always_comb begin
        base_addr = i_in.address;
        n_sp      = r_sp;
        case (op) inside
            hmbd_pkg::OP_PUSH_BYTE: begin
                base_addr = r_sp;
                n_sp      = r_sp - 16'd1;
            end
            hmbd_pkg::OP_PUSH_WORD: begin
                base_addr = r_sp;
                n_sp      = r_sp - 16'd2;
            end
            hmbd_pkg::OP_POP_BYTE: begin
                base_addr = r_sp + 16'd1;
                n_sp      = base_addr;
            end
            hmbd_pkg::OP_POP_WORD: begin
                base_addr = r_sp + 16'd2;
                n_sp      = base_addr;
            end
            default: ;
        endcase
    end

    always_comb begin
        case (op) inside
            hmbd_pkg::OP_RD_WORD, hmbd_pkg::OP_WR_WORD,
            hmbd_pkg::OP_PUSH_WORD, hmbd_pkg::OP_POP_WORD: op_word = 1'b1;
            default:                                       op_word = 1'b0;
        endcase
        case (op) inside
            hmbd_pkg::OP_WR_BYTE, hmbd_pkg::OP_WR_WORD,
            hmbd_pkg::OP_PUSH_BYTE, hmbd_pkg::OP_PUSH_WORD: op_wr = 1'b1;
            default:                                        op_wr = 1'b0;
        endcase
    end

    assign hi_addr = r_addr + 16'd1;
    assign area_lo = hmbd_pkg::decode_area(base_addr);
    assign area_hi = hmbd_pkg::decode_area(hi_addr);

    // low byte goes out in the accept cycle, high byte in S_HI
    always_comb begin
        mem_req = '0;
        if (accept) begin
            mem_req.en    = area_lo.mapped;
            mem_req.we    = op_wr;
            mem_req.addr  = base_addr[hmbd_pkg::MEM_AW-1:0];
            mem_req.wdata = i_in.write_data[7:0];
        end else if (r_state == S_HI) begin
            mem_req.en    = area_hi.mapped;
            mem_req.we    = r_wr;
            mem_req.addr  = hi_addr[hmbd_pkg::MEM_AW-1:0];
            mem_req.wdata = r_data[15:8];
        end
    end

    hmbd_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (mem_req),
        .o_rdata      (mem_rdata),
        .o_clear_busy (clear_busy)
    );

    assign last_byte = r_cur_map ? mem_rdata : 8'h00;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = op_word ? S_HI : S_FIN;
            S_HI:   n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_sp          <= hmbd_pkg::SP_RESET;
            r_stack_start <= hmbd_pkg::SP_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_stack_start <= pwdata[hmbd_pkg::ADDR_W-1:0];
                r_sp          <= pwdata[hmbd_pkg::ADDR_W-1:0];
            end else if (accept) begin
                r_sp <= n_sp;
            end
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transaction payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr    <= base_addr;
            r_data    <= i_in.write_data;
            r_word    <= op_word;
            r_wr      <= op_wr;
            r_cur_map <= area_lo.mapped;
            r_rom     <= area_lo.rom;
            r_gap     <= area_lo.gap;
        end else if (r_state == S_HI) begin
            r_lo      <= last_byte;
            r_cur_map <= area_hi.mapped;
            r_rom     <= r_rom | area_hi.rom;
            r_gap     <= r_gap | area_hi.gap;
        end
        if (r_state == S_FIN && out_free) begin
            if (r_wr) begin
                r_out_data <= '0;
            end else if (r_word) begin
                r_out_data <= {last_byte, r_lo};
            end else begin
                r_out_data <= {8'h00, last_byte};
            end
            r_out_rom <= r_rom;
            r_out_gap <= r_gap;
            r_out_sp  <= r_sp;
        end
    end

    assign i_in.ready          = (r_state == S_IDLE) && !clear_busy;
    assign o_out.valid         = r_out_valid;
    assign o_out.read_data     = r_out_data;
    assign o_out.rom_area      = r_out_rom;
    assign o_out.invalid_area  = r_out_gap;
    assign o_out.stack_pointer = r_out_sp;

    assign pready = 1'b1;
    assign prdata = {{(hmbd_pkg::PDATA_W - hmbd_pkg::ADDR_W){1'b0}}, r_stack_start};

    `HMBD_ASSERT_NOW(a_clear_quiet, i_clk, i_rst_n, clear_busy, (r_state == S_IDLE) && !r_out_valid)
    `HMBD_ASSERT_NEXT(a_hi_to_fin, i_clk, i_rst_n, r_state == S_HI, r_state == S_FIN)
    `HMBD_ASSERT_NEXT(a_fin_drains, i_clk, i_rst_n, (r_state == S_FIN) && out_free, o_out.valid && (r_state == S_IDLE))

endmodule

`default_nettype wire
